FILE: hw/rtl/tgi_pkg.sv
// Package for the triangle grid interpolator: widths, payload types, register
// indexes and reset values. It has no dependencies and comes first in compile order.
`timescale 1ns / 1ps

package tgi_pkg;

  localparam int SAMPLE_BITS    = 8;
  localparam int FRACTION_BITS  = 8;

  localparam int FIELD_BITS     = 8;
  localparam int FACTOR_BITS    = 8;
  localparam int GAIN_BITS      = 10;
  localparam int OFFSET_BITS    = 16;
  localparam int HEIGHT_BITS    = 27;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Weighted corner sum is at most max sample times n.
  localparam int WSUM_BITS      = SAMPLE_BITS + FACTOR_BITS;
  localparam int PROD_BITS      = WSUM_BITS + GAIN_BITS;
  // Quotient is bounded by max sample * max gain * 2^FRACTION_BITS.
  localparam int QUOT_RAW_BITS  = SAMPLE_BITS + GAIN_BITS + FRACTION_BITS;
  localparam int DIV_STEPS      = 4;
  localparam int DIV_STAGES     = (QUOT_RAW_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QUOT_BITS      = DIV_STAGES * DIV_STEPS;
  localparam int DIVIDEND_BITS  = QUOT_BITS + FACTOR_BITS;

  // Front stages, divider stages and the output register.
  localparam int PIPE_DEPTH     = 4 + DIV_STAGES + 1;
  localparam int COUNT_BITS     = $clog2(PIPE_DEPTH + 1);

  typedef logic [FIELD_BITS-1:0]    field_t;
  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [FACTOR_BITS-1:0]   factor_t;
  typedef logic [GAIN_BITS-1:0]     gain_t;
  typedef logic [OFFSET_BITS-1:0]   offset_t;
  typedef logic [HEIGHT_BITS-1:0]   height_t;
  typedef logic [WSUM_BITS-1:0]     wsum_t;
  typedef logic [PROD_BITS-1:0]     prod_t;
  typedef logic [QUOT_BITS-1:0]     quot_t;
  typedef logic [DIVIDEND_BITS-1:0] dividend_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_INTERP_FACTOR = 2'd0,
    CFG_HEIGHT_GAIN   = 2'd1,
    CFG_HEIGHT_OFFSET = 2'd2
  } cfg_reg_e;

  localparam factor_t FACTOR_RESET = 8'd100;
  localparam gain_t   GAIN_RESET   = 10'd230;
  localparam offset_t OFFSET_RESET = 16'd1200;

endpackage

FILE: hw/rtl/tgi_if.sv
// Valid/ready channel interfaces for the interpolator: input item, result item
// and configuration write. Depends on tgi_pkg.
`timescale 1ns / 1ps

interface tgi_in_if;
  logic            valid;
  logic            ready;
  tgi_pkg::field_t top_left;
  tgi_pkg::field_t top_right;
  tgi_pkg::field_t bottom_left;
  tgi_pkg::field_t bottom_right;
  tgi_pkg::field_t row_off;
  tgi_pkg::field_t col_off;

  modport source (output valid, top_left, top_right, bottom_left, bottom_right,
                  row_off, col_off, input ready);
  modport sink   (input valid, top_left, top_right, bottom_left, bottom_right,
                  row_off, col_off, output ready);
endinterface

interface tgi_out_if;
  logic             valid;
  logic             ready;
  tgi_pkg::height_t height;
  logic             bad_offset;

  modport source (output valid, height, bad_offset, input ready);
  modport sink   (input valid, height, bad_offset, output ready);
endinterface

interface tgi_cfg_if;
  logic                valid;
  logic                ready;
  tgi_pkg::cfg_index_t index;
  tgi_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tgi_div_pipe.sv
// Pipelined restoring divider: dividend by the 8-bit cell size, several quotient
// bits per stage, with valid bits and a per-stage stall chain. Depends on tgi_pkg.
`timescale 1ns / 1ps

module tgi_div_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tgi_pkg::factor_t    divisor_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tgi_pkg::dividend_t  in_dividend_i,
  input  logic                in_bad_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tgi_pkg::quot_t      out_quot_o,
  output logic                out_bad_o
);

  localparam int QB = tgi_pkg::QUOT_BITS;
  localparam int FB = tgi_pkg::FACTOR_BITS;
  localparam int NS = tgi_pkg::DIV_STAGES;

  logic             valid_q [NS];
  logic             bad_q   [NS];
  tgi_pkg::quot_t   acc_q   [NS];
  tgi_pkg::factor_t rem_q   [NS];
  logic [NS-1:0]    stage_rdy;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    tgi_pkg::quot_t   acc_src;
    tgi_pkg::factor_t rem_src;
    logic             valid_src;
    logic             bad_src;
    logic             rdy_next;
    tgi_pkg::quot_t   acc_d;
    tgi_pkg::factor_t rem_d;
    logic [FB:0]      trial;
    logic             qbit;

    if (k == 0) begin : g_first
      // The top bits of the dividend are already below the divisor.
      assign acc_src   = in_dividend_i[QB-1:0];
      assign rem_src   = in_dividend_i[tgi_pkg::DIVIDEND_BITS-1 -: FB];
      assign valid_src = in_valid_i;
      assign bad_src   = in_bad_i;
    end else begin : g_next
      assign acc_src   = acc_q[k-1];
      assign rem_src   = rem_q[k-1];
      assign valid_src = valid_q[k-1];
      assign bad_src   = bad_q[k-1];
    end

    if (k == NS - 1) begin : g_last
      assign rdy_next = out_ready_i;
    end else begin : g_mid
      assign rdy_next = stage_rdy[k+1];
    end

    assign stage_rdy[k] = !valid_q[k] || rdy_next;

    // Dividend bits shift out of the top of acc while quotient bits enter below.
    always_comb begin
      acc_d = acc_src;
      rem_d = rem_src;
      trial = '0;
      qbit  = 1'b0;
      for (int s = 0; s < tgi_pkg::DIV_STEPS; s++) begin
        trial = {rem_d, acc_d[QB-1]};
        if (trial >= {1'b0, divisor_i}) begin
          rem_d = FB'(trial - {1'b0, divisor_i});
          qbit  = 1'b1;
        end else begin
          rem_d = trial[FB-1:0];
          qbit  = 1'b0;
        end
        acc_d = {acc_d[QB-2:0], qbit};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_rdy[k]) begin
        valid_q[k] <= valid_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_rdy[k]) begin
        acc_q[k] <= acc_d;
        rem_q[k] <= rem_d;
        bad_q[k] <= bad_src;
      end
    end
  end

  assign in_ready_o  = stage_rdy[0];
  assign out_valid_o = valid_q[NS-1];
  assign out_quot_o  = acc_q[NS-1];
  assign out_bad_o   = bad_q[NS-1];

endmodule

FILE: hw/rtl/triangle_grid_interpolator_core.sv
// An input transfer passes through 4 front stages, 7 divider stages and 1 output
// register on its way to out_o. Throughput: one item per cycle,
// set by the fully pipelined datapath; a stage holds only while the stage after it is full.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and loads the
// registers with interp_factor 100, height_gain 230 and height_offset 1200.
`timescale 1ns / 1ps

module triangle_grid_interpolator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgi_cfg_if.sink    cfg_i,
  tgi_in_if.sink     in_i,
  tgi_out_if.source  out_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the block is idle; the block
  // does not enforce it. The datapath reads these directly, not carried along with each item.
  // ---------------------------------------------------------------------------
  tgi_pkg::factor_t factor_q;
  tgi_pkg::gain_t   gain_q;
  tgi_pkg::offset_t offset_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= tgi_pkg::FACTOR_RESET;
      gain_q   <= tgi_pkg::GAIN_RESET;
      offset_q <= tgi_pkg::OFFSET_RESET;
    end else if (cfg_i.valid) begin
      case (tgi_pkg::cfg_reg_e'(cfg_i.index))
        tgi_pkg::CFG_INTERP_FACTOR: factor_q <= tgi_pkg::factor_t'(cfg_i.data);
        tgi_pkg::CFG_HEIGHT_GAIN:   gain_q   <= tgi_pkg::gain_t'(cfg_i.data);
        tgi_pkg::CFG_HEIGHT_OFFSET: offset_q <= tgi_pkg::offset_t'(cfg_i.data);
        default: ;  // Unused index: the write is dropped.
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stall chain. Each stage loads when it is empty or the stage after it moves,
  // so bubbles collapse and an item is never lost or duplicated under backpressure.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic div_in_ready;
  logic div_valid;
  logic div_bad;
  tgi_pkg::quot_t div_quot;
  logic out_valid_q;
  logic rdy_out;

  assign rdy_out    = !out_valid_q || out_o.ready;
  assign rdy4       = !v4_q || div_in_ready;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick the triangle and its three barycentric weights.
  // Below or on the diagonal (col_off <= row_off) the corners are TL, BL, BR;
  // above it they are TL, TR, BR. In both cases the weights are n - max(r, c),
  // |r - c| and min(r, c), which sum to n.
  // ---------------------------------------------------------------------------
  logic             lower;
  logic             bad1_d;
  tgi_pkg::factor_t hi_off, lo_off;
  tgi_pkg::factor_t w0_d, w1_d, w2_d;
  tgi_pkg::sample_t a1_d, b1_d, d1_d;

  always_comb begin
    bad1_d = (tgi_pkg::factor_t'(in_i.row_off) >= factor_q) ||
             (tgi_pkg::factor_t'(in_i.col_off) >= factor_q);
    lower  = (in_i.col_off <= in_i.row_off);
    hi_off = lower ? tgi_pkg::factor_t'(in_i.row_off) : tgi_pkg::factor_t'(in_i.col_off);
    lo_off = lower ? tgi_pkg::factor_t'(in_i.col_off) : tgi_pkg::factor_t'(in_i.row_off);
    w0_d   = factor_q - hi_off;
    w1_d   = hi_off - lo_off;
    w2_d   = lo_off;
    a1_d   = tgi_pkg::sample_t'(in_i.top_left);
    b1_d   = lower ? tgi_pkg::sample_t'(in_i.bottom_left) : tgi_pkg::sample_t'(in_i.top_right);
    d1_d   = tgi_pkg::sample_t'(in_i.bottom_right);
  end

  tgi_pkg::sample_t a1_q, b1_q, d1_q;
  tgi_pkg::factor_t w0_q, w1_q, w2_q;
  logic             bad1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      a1_q   <= a1_d;
      b1_q   <= b1_d;
      d1_q   <= d1_d;
      w0_q   <= w0_d;
      w1_q   <= w1_d;
      w2_q   <= w2_d;
      bad1_q <= bad1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the three small corner-times-weight products, in parallel.
  // ---------------------------------------------------------------------------
  tgi_pkg::wsum_t p0_q, p1_q, p2_q;
  logic           bad2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p0_q   <= tgi_pkg::wsum_t'(a1_q) * tgi_pkg::wsum_t'(w0_q);
      p1_q   <= tgi_pkg::wsum_t'(b1_q) * tgi_pkg::wsum_t'(w1_q);
      p2_q   <= tgi_pkg::wsum_t'(d1_q) * tgi_pkg::wsum_t'(w2_q);
      bad2_q <= bad1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: weighted sum S. For an in-range item S is at most max sample
  // times n, so it fits the sum width without a carry out.
  // ---------------------------------------------------------------------------
  tgi_pkg::wsum_t sum3_q;
  logic           bad3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      sum3_q <= p0_q + p1_q + p2_q;
      bad3_q <= bad2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: scale by the height gain.
  // ---------------------------------------------------------------------------
  tgi_pkg::prod_t prod4_q;
  logic           bad4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      prod4_q <= tgi_pkg::prod_t'(sum3_q) * tgi_pkg::prod_t'(gain_q);
      bad4_q  <= bad3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: floor(S * gain * 2^FRACTION_BITS / n). The fraction bits enter as
  // zeros below the product. For an out-of-range item n may be zero; the
  // quotient is then meaningless and is replaced by zero at the output.
  // ---------------------------------------------------------------------------
  tgi_pkg::dividend_t dividend;

  assign dividend = tgi_pkg::dividend_t'(prod4_q) << tgi_pkg::FRACTION_BITS;

  tgi_div_pipe u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .divisor_i     (factor_q),
    .in_valid_i    (v4_q),
    .in_ready_o    (div_in_ready),
    .in_dividend_i (dividend),
    .in_bad_i      (bad4_q),
    .out_valid_o   (div_valid),
    .out_ready_i   (rdy_out),
    .out_quot_o    (div_quot),
    .out_bad_o     (div_bad)
  );

  // ---------------------------------------------------------------------------
  // Output register: add the offset in fixed point and force zero on a bad
  // offset. The sum is taken modulo the height width.
  // ---------------------------------------------------------------------------
  tgi_pkg::height_t height_d, height_q;
  logic             bad_out_q;

  assign height_d = div_bad ? '0
                  : tgi_pkg::height_t'(div_quot) +
                    (tgi_pkg::height_t'(offset_q) << tgi_pkg::FRACTION_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      height_q  <= height_d;
      bad_out_q <= div_bad;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.height     = height_q;
  assign out_o.bad_offset = bad_out_q;

endmodule

FILE: hw/rtl/tgi_checker.sv
// Port-level checks for the interpolator top level and the bind that attaches
// them. Depends on tgi_pkg and triangle_grid_interpolator_core.
`timescale 1ns / 1ps

module tgi_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                cfg_valid_i,
  input logic                cfg_ready_i,
  input tgi_pkg::cfg_index_t cfg_index_i,
  input tgi_pkg::cfg_data_t  cfg_data_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input tgi_pkg::height_t    out_height_i,
  input logic                out_bad_i
);

  logic             in_fire;
  logic             out_fire;
  tgi_pkg::count_t  pending_q;
  tgi_pkg::offset_t offset_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + tgi_pkg::count_t'(in_fire) - tgi_pkg::count_t'(out_fire);
    end
  end

  // Shadow copy of the offset register as seen on the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= tgi_pkg::OFFSET_RESET;
    end else if (cfg_valid_i && cfg_ready_i &&
                 cfg_index_i == tgi_pkg::CFG_HEIGHT_OFFSET) begin
      offset_q <= tgi_pkg::offset_t'(cfg_data_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_height_i) && $stable(out_bad_i))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bad_i |-> out_height_i == '0)
    else $error("bad offset with nonzero height");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result without an accepted item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= tgi_pkg::count_t'(tgi_pkg::PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_offset_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_bad_i |->
      out_height_i >= (tgi_pkg::height_t'(offset_q) << tgi_pkg::FRACTION_BITS))
    else $error("height below the configured offset");

endmodule

bind triangle_grid_interpolator_core tgi_checker u_tgi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready),
  .cfg_index_i  (cfg_i.index),
  .cfg_data_i   (cfg_i.data),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_height_i (out_o.height),
  .out_bad_i    (out_o.bad_offset)
);

FILE: sim/testbench.sv
// Self-checking testbench for triangle_grid_interpolator_core: cell samples go in,
// mapped heights come out and are compared against an in-bench height predictor.
// Depends on tgi_pkg, the tgi channel interfaces and the core itself.
`timescale 1ns / 1ps

module testbench;

  // One coarse cell with the pixel position inside it, as carried by in_i.
  typedef struct packed {
    tgi_pkg::field_t top_left;
    tgi_pkg::field_t top_right;
    tgi_pkg::field_t bottom_left;
    tgi_pkg::field_t bottom_right;
    tgi_pkg::field_t row_off;
    tgi_pkg::field_t col_off;
  } cell_t;

  // One mapped height, as carried by out_o.
  typedef struct packed {
    tgi_pkg::height_t height;
    logic             bad_offset;
  } height_result_t;

  // Index 3 has no register behind it; a write there must leave the others alone.
  localparam tgi_pkg::cfg_index_t CFG_UNUSED_INDEX = 2'd3;
  localparam int RANDOM_PHASES    = 8;
  localparam int CELLS_PER_PHASE  = 200;
  localparam int ZERO_FACTOR_CELLS = 20;

  logic clk_i;
  logic rst_ni;

  tgi_cfg_if cfg_if ();
  tgi_in_if  in_if ();
  tgi_out_if out_if ();

  triangle_grid_interpolator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Mirror of the block's registers; only updated on an accepted register write.
  tgi_pkg::factor_t cur_factor;
  tgi_pkg::gain_t   cur_gain;
  tgi_pkg::offset_t cur_offset;

  // Heights predicted for accepted cells, oldest first.
  height_result_t pending_heights[$];
  height_result_t want;

  int fail_count;
  int cells_sent;
  int bad_cells_sent;
  int settings_used;
  int burst_left;

  // Receiver stall pattern state.
  int stall_mode;
  int stall_count;

  // 10 ns clock.
  always #5 clk_i = ~clk_i;

  // Works out the height that the block must produce for one cell under the
  // current register values. The cell is split along its main diagonal: pixels
  // on or below the diagonal blend top-left, bottom-left and bottom-right, the
  // others blend top-left, top-right and bottom-right. The weighted sum carries
  // a factor n, which the division by n takes back out after the gain and the
  // fractional shift are applied.
  function automatic height_result_t predict_height(cell_t pix);
    longint unsigned n, r, c, tl, tr, bl, br, wsum, scaled;
    height_result_t res;
    n  = 64'(cur_factor);
    r  = 64'(pix.row_off);
    c  = 64'(pix.col_off);
    tl = 64'(tgi_pkg::sample_t'(pix.top_left));
    tr = 64'(tgi_pkg::sample_t'(pix.top_right));
    bl = 64'(tgi_pkg::sample_t'(pix.bottom_left));
    br = 64'(tgi_pkg::sample_t'(pix.bottom_right));
    res.height     = '0;
    res.bad_offset = 1'b1;
    // An offset at or past n (every offset when n is zero) gives a flagged zero.
    if (r < n && c < n) begin
      if (c <= r) begin
        wsum = tl * (n - r) + bl * (r - c) + br * c;
      end else begin
        wsum = tl * (n - c) + tr * (c - r) + br * r;
      end
      scaled = ((wsum * 64'(cur_gain)) << tgi_pkg::FRACTION_BITS) / n;
      scaled += 64'(cur_offset) << tgi_pkg::FRACTION_BITS;
      res.height     = tgi_pkg::height_t'(scaled);
      res.bad_offset = 1'b0;
    end
    return res;
  endfunction

  function automatic cell_t make_cell(int tl, int tr, int bl, int br, int r, int c);
    cell_t pix;
    pix.top_left     = tgi_pkg::field_t'(tl);
    pix.top_right    = tgi_pkg::field_t'(tr);
    pix.bottom_left  = tgi_pkg::field_t'(bl);
    pix.bottom_right = tgi_pkg::field_t'(br);
    pix.row_off      = tgi_pkg::field_t'(r);
    pix.col_off      = tgi_pkg::field_t'(c);
    return pix;
  endfunction

  // Random cell. Most land inside the cell, a few on the diagonal, and about
  // one in ten carries an offset that is out of range.
  function automatic cell_t random_cell();
    cell_t pix;
    int n;
    n = int'(cur_factor);
    pix = make_cell($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), 0, 0);
    if (n > 0 && $urandom_range(0, 9) != 0) begin
      pix.row_off = tgi_pkg::field_t'($urandom_range(0, n - 1));
      if ($urandom_range(0, 3) == 0) begin
        pix.col_off = pix.row_off;
      end else begin
        pix.col_off = tgi_pkg::field_t'($urandom_range(0, n - 1));
      end
    end else begin
      pix.row_off = tgi_pkg::field_t'($urandom_range(0, 255));
      pix.col_off = tgi_pkg::field_t'($urandom_range(0, 255));
      if (int'(pix.row_off) < n && int'(pix.col_off) < n) begin
        if ($urandom_range(0, 1) == 0) begin
          pix.row_off = tgi_pkg::field_t'($urandom_range(n, 255));
        end else begin
          pix.col_off = tgi_pkg::field_t'($urandom_range(n, 255));
        end
      end
    end
    return pix;
  endfunction

  // Sends one cell. The sender works in bursts: valid stays high across
  // back-to-back transfers inside a burst and may drop for a random gap between
  // bursts. The expected height is queued when the transfer happens.
  task automatic drive_cell(cell_t pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.top_left     <= pix.top_left;
    in_if.top_right    <= pix.top_right;
    in_if.bottom_left  <= pix.bottom_left;
    in_if.bottom_right <= pix.bottom_right;
    in_if.row_off      <= pix.row_off;
    in_if.col_off      <= pix.col_off;
    do @(posedge clk_i); while (!in_if.ready);
    pending_heights.push_back(predict_height(pix));
    cells_sent++;
    if (pix.row_off >= cur_factor || pix.col_off >= cur_factor) bad_cells_sent++;
    burst_left--;
  endtask

  // Drops valid and waits until every queued height has come back and the
  // pipeline has emptied, so that the block is idle before its registers change.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (tgi_pkg::PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // One register write transfer; the mirror follows the write when it is taken.
  task automatic write_register(tgi_pkg::cfg_index_t idx, tgi_pkg::cfg_data_t data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      tgi_pkg::CFG_INTERP_FACTOR: cur_factor = tgi_pkg::factor_t'(data);
      tgi_pkg::CFG_HEIGHT_GAIN:   cur_gain   = tgi_pkg::gain_t'(data);
      tgi_pkg::CFG_HEIGHT_OFFSET: cur_offset = tgi_pkg::offset_t'(data);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Loads all three registers. The unused upper data bits of the narrower
  // registers carry random junk, which the block has to drop.
  task automatic apply_setting(int factor, int gain, int offset);
    logic [7:0] junk;
    drain_pipeline();
    junk = 8'($urandom);
    write_register(tgi_pkg::CFG_INTERP_FACTOR,
                   tgi_pkg::cfg_data_t'({junk, tgi_pkg::factor_t'(factor)}));
    junk = 8'($urandom);
    write_register(tgi_pkg::CFG_HEIGHT_GAIN,
                   tgi_pkg::cfg_data_t'({junk[5:0], tgi_pkg::gain_t'(gain)}));
    write_register(tgi_pkg::CFG_HEIGHT_OFFSET, tgi_pkg::cfg_data_t'(offset));
    settings_used++;
  endtask

  // Directed cells under the reset values (n = 100, gain 230, offset 1200):
  // empty and full cells, both triangles, the diagonal and the step just past
  // it, the far edges of the cell, and offsets that fall outside it.
  task automatic test_reset_defaults();
    settings_used++;
    drive_cell(make_cell(0, 0, 0, 0, 0, 0));
    drive_cell(make_cell(255, 255, 255, 255, 0, 0));
    drive_cell(make_cell(255, 255, 255, 255, 99, 99));
    drive_cell(make_cell(255, 0, 0, 0, 99, 0));
    drive_cell(make_cell(0, 255, 0, 0, 0, 99));
    drive_cell(make_cell(17, 200, 93, 140, 40, 41));
    drive_cell(make_cell(17, 200, 93, 140, 50, 50));
    drive_cell(make_cell(200, 10, 250, 3, 100, 0));
    drive_cell(make_cell(200, 10, 250, 3, 0, 100));
    drive_cell(make_cell(255, 255, 255, 255, 255, 255));
  endtask

  // Register extremes: the smallest and largest divisor, the gain and offset
  // at both ends, a write to an index with no register, and a zero divisor,
  // under which every offset is out of range and no division takes place.
  task automatic test_register_extremes();
    apply_setting(1, 1023, 65535);
    drive_cell(make_cell(255, 255, 255, 255, 0, 0));
    drive_cell(make_cell(255, 255, 255, 255, 1, 0));

    apply_setting(255, 1023, 65535);
    drive_cell(make_cell(255, 255, 255, 255, 254, 254));
    drive_cell(make_cell(255, 0, 255, 255, 254, 0));
    drive_cell(make_cell(255, 255, 0, 255, 0, 254));
    drive_cell(make_cell(255, 255, 255, 255, 255, 255));

    apply_setting(37, 0, 0);
    drive_cell(make_cell(255, 255, 255, 255, 12, 30));

    // The write below must change nothing, so the next cell still sees gain 0.
    drain_pipeline();
    write_register(CFG_UNUSED_INDEX, 16'hFFFF);
    drive_cell(make_cell(128, 64, 32, 16, 20, 5));

    apply_setting(0, 512, 300);
    drive_cell(make_cell(255, 255, 255, 255, 0, 0));
    drive_cell(make_cell(1, 2, 3, 4, 0, 0));
  endtask

  // Random cells under a run of register settings, the extremes among them.
  task automatic test_random_cells();
    int count;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      count = CELLS_PER_PHASE;
      case (phase)
        0: apply_setting(255, 1023, 65535);
        1: apply_setting(1, $urandom_range(0, 1023), $urandom_range(0, 65535));
        2: apply_setting(2, $urandom_range(0, 1023), 0);
        3: begin
          apply_setting(0, $urandom_range(0, 1023), $urandom_range(0, 65535));
          count = ZERO_FACTOR_CELLS;
        end
        4: apply_setting(255, $urandom_range(0, 1023), $urandom_range(0, 65535));
        default: apply_setting($urandom_range(1, 255), $urandom_range(0, 1023),
                               $urandom_range(0, 65535));
      endcase
      repeat (count) drive_cell(random_cell());
    end
  endtask

  // Receiver: ready follows a stall pattern that switches between always
  // ready, mostly ready, mostly stalled and a fixed periodic stall.
  always @(negedge clk_i) begin
    if (stall_count == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_count = $urandom_range(20, 80);
    end else begin
      stall_count--;
    end
    case (stall_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= ($urandom_range(0, 3) != 0);
      2:       out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= (stall_count % 4 != 3);
    endcase
  end

  // Result checker: every height transfer is matched against the oldest
  // prediction, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_heights.size() == 0) begin
        $error("unexpected result: height %0d bad_offset %0b",
               out_if.height, out_if.bad_offset);
        fail_count++;
      end else begin
        want = pending_heights.pop_front();
        if (out_if.height !== want.height) begin
          $error("height mismatch: expected %0d, actual %0d", want.height, out_if.height);
          fail_count++;
        end
        if (out_if.bad_offset !== want.bad_offset) begin
          $error("bad_offset mismatch: expected %0b, actual %0b",
                 want.bad_offset, out_if.bad_offset);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset once, then the tests in turn, then the drain and the verdict.
  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    in_if.valid        = 1'b0;
    in_if.top_left     = '0;
    in_if.top_right    = '0;
    in_if.bottom_left  = '0;
    in_if.bottom_right = '0;
    in_if.row_off      = '0;
    in_if.col_off      = '0;
    out_if.ready = 1'b0;
    cur_factor   = tgi_pkg::FACTOR_RESET;
    cur_gain     = tgi_pkg::GAIN_RESET;
    cur_offset   = tgi_pkg::OFFSET_RESET;
    fail_count     = 0;
    cells_sent     = 0;
    bad_cells_sent = 0;
    settings_used  = 0;
    burst_left     = 0;
    stall_mode     = 0;
    stall_count    = 0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_cells();

    // Let the last heights come back, then give the pipeline time to show
    // anything spurious.
    drain_pipeline();
    repeat (2 * tgi_pkg::PIPE_DEPTH) @(posedge clk_i);
    if (pending_heights.size() != 0) begin
      $error("%0d predicted heights never arrived", pending_heights.size());
      fail_count++;
    end

    $display("Sent %0d cells (%0d with offsets outside the cell) under %0d register settings.",
             cells_sent, bad_cells_sent, settings_used);
    $display("Receiver stalls and sender gaps varied throughout; %0d checks failed.",
             fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout waiting for the interpolator.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
